>>> rtl/factor_vector_sgd_step_top_defines.svh
// assertion macros used by the port checker file
`ifndef FACTOR_VECTOR_SGD_STEP_TOP_DEFINES_SVH
`define FACTOR_VECTOR_SGD_STEP_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define FVS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define FVS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fvs_pkg.sv
// types, codes and shared arithmetic for the factor vector sgd block
package fvs_pkg;

    // item kinds
    localparam logic KIND_TRAIN = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // id field range
    localparam int ID_RANGE = 2048;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_FEATURE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZATION = 2'd2;

    // register reset values
    localparam logic [3:0]  ACTIVE_FEATURE_RESET = 4'd0;
    localparam logic [15:0] LEARN_RATE_RESET     = 16'd655;
    localparam logic [15:0] REGULARIZATION_RESET = 16'd66;

    // table reset value, 0.1 in Q16.16
    localparam logic signed [31:0] INIT_VALUE = 32'sd6554;

    // update pipeline tags
    localparam logic TAG_A = 1'b0;
    localparam logic TAG_B = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [10:0]        first_id;
        logic [10:0]        second_id;
        logic signed [31:0] target;
        logic [3:0]         element;
    } in_t;

    typedef struct packed {
        logic signed [31:0] predicted;
        logic signed [31:0] error_value;
        logic signed [31:0] read_value;
        logic               saturated;
    } out_t;

    typedef struct packed {
        logic clear;
        logic valid;
    } dot_ctl_t;

    typedef struct packed {
        logic               valid;
        logic               tag;
        logic signed [31:0] err;
        logic signed [31:0] self_val;
        logic signed [31:0] other_val;
    } upd_req_t;

    typedef struct packed {
        logic               valid;
        logic               tag;
        logic signed [49:0] delta;
    } upd_rsp_t;

    // round frac 32 to frac 16: floor((x + 2^15) / 2^16)
    function automatic logic signed [49:0] round16(input logic signed [65:0] x);
        logic signed [65:0] t;
        t = x + 66'sd32768;
        return t[65:16];
    endfunction

endpackage

>>> rtl/fvs_vec_mem.sv
// vector table memory, one write port and two registered read ports
module fvs_vec_mem #(
    parameter int DEPTH = 20480,
    parameter int AW    = 15
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    input  logic [AW-1:0]       rd_addr_a,
    input  logic [AW-1:0]       rd_addr_b,
    output logic signed [31:0]  rd_data_a,
    output logic signed [31:0]  rd_data_b
);

    logic signed [31:0] mem_reg [DEPTH];
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read ports, registered
    always_ff @(posedge aclk) begin
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

>>> rtl/fvs_dot.sv
// dot product unit: multiply, round and accumulate one element pair a cycle
module fvs_dot import fvs_pkg::*; #(
    parameter int ACC_W = 54
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dot_ctl_t                ctl,
    input  logic signed [31:0]      elem_a,
    input  logic signed [31:0]      elem_b,
    output logic signed [ACC_W-1:0] acc,
    output logic                    busy
);

    logic signed [63:0]      prod_reg;
    logic signed [63:0]      prod_next;
    logic                    prod_v_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [49:0]      prod_rnd;

    // product, rounding and accumulation
    always_comb begin
        prod_next = elem_a * elem_b;
        prod_rnd  = round16(66'(prod_reg));
        acc_next  = acc_reg;
        if (ctl.clear) begin
            acc_next = '0;
        end else if (prod_v_reg) begin
            acc_next = acc_reg + ACC_W'(prod_rnd);
        end
    end

    // stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= ctl.valid;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign busy = ctl.valid | prod_v_reg;

endmodule

>>> rtl/fvs_upd.sv
// gradient delta pipeline: round16(round16(err*other - reg*self) * lr)
module fvs_upd import fvs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  upd_req_t    req,
    input  logic [15:0] learn_rate,
    input  logic [15:0] regularization,
    output upd_rsp_t    rsp
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [63:0] p1_reg, p1_next;
    logic signed [48:0] p2_reg, p2_next;
    logic signed [65:0] diff;
    logic signed [49:0] r_reg, r_next;
    logic signed [65:0] m_reg, m_next;
    logic signed [49:0] delta_reg, delta_next;

    // arithmetic between stages
    always_comb begin
        p1_next    = req.err * req.other_val;
        p2_next    = $signed({1'b0, regularization}) * req.self_val;
        diff       = 66'(p1_reg) - 66'(p2_reg);
        r_next     = round16(diff);
        m_next     = r_reg * $signed({1'b0, learn_rate});
        delta_next = round16(m_reg);
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage data and tags
    always_ff @(posedge aclk) begin
        t1_reg    <= req.tag;
        t2_reg    <= t1_reg;
        t3_reg    <= t2_reg;
        t4_reg    <= t3_reg;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        r_reg     <= r_next;
        m_reg     <= m_next;
        delta_reg <= delta_next;
    end

    assign rsp.valid = v4_reg;
    assign rsp.tag   = t4_reg;
    assign rsp.delta = delta_reg;

endmodule

>>> rtl/factor_vector_sgd_step_top.sv
// factor vector sgd step: sequencer, registers and result stage around the vector memory
//
//  channel  | direction | handshake            | payload
//  s_       | in        | s_valid / s_ready    | s_data (in_t)
//  m_       | out       | m_valid / m_ready    | m_data (out_t)
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// after reset a clearing pass writes 0.1 into all NUM_IDS*NUM_FEATURES entries, one a cycle;
// s_ready stays low for those cycles.
// train item: the element sweep over the memory's two read ports, the error, the delta
// pipeline and the write-back; the update is skipped when the active feature is out of range.
// read item: one element read. both kinds first reduce the ids when NUM_IDS < 2048.
// a finished result waits in the output register; one more item is taken meanwhile and
// holds in its last step until the output register frees up.
module factor_vector_sgd_step_top import fvs_pkg::*; #(
    parameter int NUM_IDS      = 2048,
    parameter int NUM_FEATURES = 10
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH    = NUM_IDS * NUM_FEATURES;
    localparam int AW       = $clog2(DEPTH);
    localparam int KW       = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int AccW     = 50 + $clog2(NUM_FEATURES + 1);
    localparam int ModSteps = $clog2((ID_RANGE + NUM_IDS - 1) / NUM_IDS);
    localparam int ModLast  = (ModSteps > 0) ? ModSteps - 1 : 0;
    localparam int MSW      = (ModSteps > 1) ? $clog2(ModSteps) : 1;
    localparam bit UseMod   = (ModSteps > 0);
    localparam logic [11:0] ModBase   = (NUM_IDS < ID_RANGE) ? 12'(NUM_IDS) : 12'd0;
    localparam logic [6:0]  NumFeatV  = 7'(NUM_FEATURES);

    // sequencer states
    localparam logic [3:0] ST_CLEAR     = 4'd0;
    localparam logic [3:0] ST_IDLE      = 4'd1;
    localparam logic [3:0] ST_MOD       = 4'd2;
    localparam logic [3:0] ST_BASE      = 4'd3;
    localparam logic [3:0] ST_RD_ISSUE  = 4'd4;
    localparam logic [3:0] ST_RD_DATA   = 4'd5;
    localparam logic [3:0] ST_DOT_ISSUE = 4'd6;
    localparam logic [3:0] ST_DOT_WAIT  = 4'd7;
    localparam logic [3:0] ST_ERR       = 4'd8;
    localparam logic [3:0] ST_UPD_A     = 4'd9;
    localparam logic [3:0] ST_UPD_B     = 4'd10;
    localparam logic [3:0] ST_UPD_WAIT  = 4'd11;
    localparam logic [3:0] ST_WR_A      = 4'd12;
    localparam logic [3:0] ST_WR_B      = 4'd13;
    localparam logic [3:0] ST_DONE      = 4'd14;

    logic [3:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic                kind_reg, kind_next;
    logic [10:0]         id1_reg, id1_next;
    logic [10:0]         id2_reg, id2_next;
    logic signed [31:0]  target_reg, target_next;
    logic [3:0]          elem_reg, elem_next;
    logic [MSW-1:0]      mod_s_reg, mod_s_next;
    logic [AW-1:0]       base1_reg, base1_next;
    logic [AW-1:0]       base2_reg, base2_next;
    logic [KW-1:0]       k_reg, k_next;
    logic                rd_v_reg, rd_v_next;
    logic                rd_cap_reg, rd_cap_next;
    logic signed [31:0]  a_reg, a_next;
    logic signed [31:0]  b_reg, b_next;
    logic signed [31:0]  pred_reg, pred_next;
    logic signed [31:0]  err_reg, err_next;
    logic signed [31:0]  rv_reg, rv_next;
    logic                sat_reg, sat_next;
    logic signed [49:0]  da_reg, da_next;
    logic signed [49:0]  db_reg, db_next;
    logic                m_valid_reg, m_valid_next;
    out_t                m_data_reg, m_data_next;
    logic [3:0]          af_reg, af_next;
    logic [15:0]         lr_reg, lr_next;
    logic [15:0]         rg_reg, rg_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic signed [31:0]  mem_wdata;
    logic [AW-1:0]       mem_raddr_a;
    logic [AW-1:0]       mem_raddr_b;
    logic signed [31:0]  mem_rdata_a;
    logic signed [31:0]  mem_rdata_b;

    dot_ctl_t            dot_ctl;
    logic signed [AccW-1:0] dot_acc;
    logic                dot_busy;
    upd_req_t            upd_req;
    upd_rsp_t            upd_rsp;

    logic [AW-1:0]       addr1_k, addr2_k, addr1_e, addr1_f, addr2_f;
    logic                same_id, elem_ok, af_ok, k_last, k_hit;
    logic [11:0]         mod_sub;
    logic [11:0]         id1_ext, id2_ext;
    logic signed [63:0]  sum_a, sum_b;
    logic [32:0]         pred_sat, err_sat, wa_sat, wb_sat;

    // clip to signed 32 bits, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [63:0] x);
        logic [32:0] r;
        if (x > 64'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (x < -64'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    // vector memory
    fvs_vec_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk      (aclk),
        .wr_en     (mem_we),
        .wr_addr   (mem_waddr),
        .wr_data   (mem_wdata),
        .rd_addr_a (mem_raddr_a),
        .rd_addr_b (mem_raddr_b),
        .rd_data_a (mem_rdata_a),
        .rd_data_b (mem_rdata_b)
    );

    // dot product accumulator
    fvs_dot #(
        .ACC_W (AccW)
    ) u_dot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (dot_ctl),
        .elem_a  (mem_rdata_a),
        .elem_b  (mem_rdata_b),
        .acc     (dot_acc),
        .busy    (dot_busy)
    );

    // gradient delta pipeline
    fvs_upd u_upd (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (upd_req),
        .learn_rate     (lr_reg),
        .regularization (rg_reg),
        .rsp            (upd_rsp)
    );

    // addresses and flags
    always_comb begin
        addr1_k  = base1_reg + AW'(k_reg);
        addr2_k  = base2_reg + AW'(k_reg);
        addr1_e  = base1_reg + AW'(elem_reg);
        addr1_f  = base1_reg + AW'(af_reg);
        addr2_f  = base2_reg + AW'(af_reg);
        same_id  = (id1_reg == id2_reg);
        elem_ok  = ({3'b000, elem_reg} < NumFeatV);
        af_ok    = ({3'b000, af_reg} < NumFeatV);
        k_last   = (k_reg == KW'(NUM_FEATURES - 1));
        k_hit    = (7'(k_reg) == {3'b000, af_reg});
        mod_sub  = ModBase << mod_s_reg;
        id1_ext  = {1'b0, id1_reg};
        id2_ext  = {1'b0, id2_reg};
        sum_a    = 64'(a_reg) + 64'(da_reg) + (same_id ? 64'(db_reg) : 64'sd0);
        sum_b    = 64'(b_reg) + 64'(db_reg);
        pred_sat = sat32(64'(dot_acc));
        err_sat  = sat32(64'(target_reg) - 64'(pred_reg));
        wa_sat   = sat32(sum_a);
        wb_sat   = sat32(sum_b);
        mem_raddr_a = (state_reg == ST_RD_ISSUE) ? addr1_e : addr1_k;
        mem_raddr_b = addr2_k;
    end

    // sequencer and datapath next values
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        kind_next     = kind_reg;
        id1_next      = id1_reg;
        id2_next      = id2_reg;
        target_next   = target_reg;
        elem_next     = elem_reg;
        mod_s_next    = mod_s_reg;
        base1_next    = base1_reg;
        base2_next    = base2_reg;
        k_next        = k_reg;
        rd_v_next     = 1'b0;
        rd_cap_next   = 1'b0;
        a_next        = a_reg;
        b_next        = b_reg;
        pred_next     = pred_reg;
        err_next      = err_reg;
        rv_next       = rv_reg;
        sat_next      = sat_reg;
        da_next       = da_reg;
        db_next       = db_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_data_next   = m_data_reg;
        af_next       = af_reg;
        lr_next       = lr_reg;
        rg_next       = rg_reg;
        s_ready       = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr1_f;
        mem_wdata     = wa_sat[31:0];
        dot_ctl.clear = 1'b0;
        dot_ctl.valid = rd_v_reg;
        upd_req.valid     = 1'b0;
        upd_req.tag       = TAG_A;
        upd_req.err       = err_reg;
        upd_req.self_val  = a_reg;
        upd_req.other_val = b_reg;

        // configuration transfer
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ACTIVE_FEATURE: af_next = cfg_data[3:0];
                CFG_LEARN_RATE:     lr_next = cfg_data;
                CFG_REGULARIZATION: rg_next = cfg_data;
                default:            ;
            endcase
        end

        // catch the active element pair on its way to the dot unit
        if (rd_v_reg && rd_cap_reg) begin
            a_next = mem_rdata_a;
            b_next = mem_rdata_b;
        end

        // catch deltas from the update pipeline
        if (upd_rsp.valid) begin
            if (upd_rsp.tag == TAG_B) begin
                db_next = upd_rsp.delta;
            end else begin
                da_next = upd_rsp.delta;
            end
        end

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = INIT_VALUE;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    kind_next   = s_data.kind;
                    id1_next    = s_data.first_id;
                    id2_next    = s_data.second_id;
                    target_next = s_data.target;
                    elem_next   = s_data.element;
                    pred_next   = '0;
                    err_next    = '0;
                    rv_next     = '0;
                    sat_next    = 1'b0;
                    mod_s_next  = MSW'(ModLast);
                    state_next  = UseMod ? ST_MOD : ST_BASE;
                end
            end
            ST_MOD: begin
                // one restoring step of id modulo NUM_IDS on both ids
                if (id1_ext >= mod_sub) begin
                    id1_next = 11'(id1_ext - mod_sub);
                end
                if (id2_ext >= mod_sub) begin
                    id2_next = 11'(id2_ext - mod_sub);
                end
                if (mod_s_reg == '0) begin
                    state_next = ST_BASE;
                end else begin
                    mod_s_next = mod_s_reg - 1'b1;
                end
            end
            ST_BASE: begin
                base1_next    = AW'(id1_reg) * AW'(NUM_FEATURES);
                base2_next    = AW'(id2_reg) * AW'(NUM_FEATURES);
                k_next        = '0;
                dot_ctl.clear = 1'b1;
                state_next    = (kind_reg == KIND_READ) ? ST_RD_ISSUE : ST_DOT_ISSUE;
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                rv_next    = elem_ok ? mem_rdata_a : 32'sd0;
                state_next = ST_DONE;
            end
            ST_DOT_ISSUE: begin
                rd_v_next   = 1'b1;
                rd_cap_next = k_hit;
                if (k_last) begin
                    state_next = ST_DOT_WAIT;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_DOT_WAIT: begin
                if (!dot_busy) begin
                    pred_next  = pred_sat[31:0];
                    sat_next   = sat_reg | pred_sat[32];
                    state_next = ST_ERR;
                end
            end
            ST_ERR: begin
                err_next   = err_sat[31:0];
                sat_next   = sat_reg | err_sat[32];
                state_next = af_ok ? ST_UPD_A : ST_DONE;
            end
            ST_UPD_A: begin
                upd_req.valid = 1'b1;
                state_next    = ST_UPD_B;
            end
            ST_UPD_B: begin
                upd_req.valid     = 1'b1;
                upd_req.tag       = TAG_B;
                upd_req.self_val  = b_reg;
                upd_req.other_val = a_reg;
                state_next        = ST_UPD_WAIT;
            end
            ST_UPD_WAIT: begin
                if (upd_rsp.valid && (upd_rsp.tag == TAG_B)) begin
                    state_next = ST_WR_A;
                end
            end
            ST_WR_A: begin
                // equal ids: both deltas land in the one element
                mem_we     = 1'b1;
                mem_waddr  = addr1_f;
                mem_wdata  = wa_sat[31:0];
                rv_next    = wa_sat[31:0];
                sat_next   = sat_reg | wa_sat[32];
                state_next = same_id ? ST_DONE : ST_WR_B;
            end
            ST_WR_B: begin
                mem_we     = 1'b1;
                mem_waddr  = addr2_f;
                mem_wdata  = wb_sat[31:0];
                sat_next   = sat_reg | wb_sat[32];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.predicted   = pred_reg;
                    m_data_next.error_value = err_reg;
                    m_data_next.read_value  = rv_reg;
                    m_data_next.saturated   = sat_reg;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            rd_v_reg     <= 1'b0;
            rd_cap_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            af_reg       <= ACTIVE_FEATURE_RESET;
            lr_reg       <= LEARN_RATE_RESET;
            rg_reg       <= REGULARIZATION_RESET;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            rd_v_reg     <= rd_v_next;
            rd_cap_reg   <= rd_cap_next;
            m_valid_reg  <= m_valid_next;
            af_reg       <= af_next;
            lr_reg       <= lr_next;
            rg_reg       <= rg_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        id1_reg    <= id1_next;
        id2_reg    <= id2_next;
        target_reg <= target_next;
        elem_reg   <= elem_next;
        mod_s_reg  <= mod_s_next;
        base1_reg  <= base1_next;
        base2_reg  <= base2_next;
        k_reg      <= k_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        pred_reg   <= pred_next;
        err_reg    <= err_next;
        rv_reg     <= rv_next;
        sat_reg    <= sat_next;
        da_reg     <= da_next;
        db_reg     <= db_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

>>> rtl/fvs_check.sv
// port checker for the factor vector sgd block, bound to the top level
`include "factor_vector_sgd_step_top_defines.svh"

module fvs_check import fvs_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    logic [1:0] outst_reg, outst_next;
    logic       s_xfer, m_xfer;

    // items taken but not yet delivered
    always_comb begin
        s_xfer     = s_valid & s_ready;
        m_xfer     = m_valid & m_ready;
        outst_next = outst_reg;
        if (s_xfer && !m_xfer) begin
            outst_next = outst_reg + 2'd1;
        end else if (m_xfer && !s_xfer) begin
            outst_next = outst_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outst_reg <= '0;
        end else begin
            outst_reg <= outst_next;
        end
    end

    // stalled result holds
    `FVS_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    // no result without an item in flight
    `FVS_ASSERT_NOW(a_no_phantom, m_valid, outst_reg != 2'd0, "result with no item in flight")
    // at most one item in work plus one waiting result
    `FVS_ASSERT_NOW(a_two_max, outst_reg == 2'd2, !s_ready, "third item taken")
    // clearing pass keeps input closed right after reset
    `FVS_ASSERT_NOW(a_clear_closed, $past(!aresetn), !s_ready, "input open during clearing pass")

endmodule

bind factor_vector_sgd_step_top fvs_check u_fvs_check (.*);
